### rtl/core/lkvc_pkg.sv
// shared types and constants for the lru key/value cache
package lkvc_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CAP_W   = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  // request kinds
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the request
    logic lookup;  // compare key against all entries, register hit
    logic access;  // hit: read or write the value, make entry most recent
    logic evict;   // drop the least recent entry
    logic insert;  // place new key in lowest free slot
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic hit;     // registered lookup result
    logic is_put;  // request is a put
    logic full;    // occupancy at or above the effective capacity
  } status_t;

endpackage

### rtl/core/lkvc_ram.sv
// generic single write port ram with registered read
module lkvc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lkvc_ctrl.sv
// request sequencer for the lru key/value cache
module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy,
  output logic    done_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CMP   = 5'b00010,
    S_ACT   = 5'b00100,
    S_EVICT = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.lookup = 1'b1;
        state_d      = S_ACT;
      end
      S_ACT: begin
        if (status_i.hit) begin
          cmd_o.access = 1'b1;
          state_d      = S_RESP;
        end else if (status_i.is_put) begin
          state_d = S_EVICT;
        end else begin
          state_d = S_RESP;
        end
      end
      S_EVICT: begin
        if (status_i.full) begin
          cmd_o.evict = 1'b1;
        end else begin
          cmd_o.insert = 1'b1;
          state_d      = S_RESP;
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

endmodule

### rtl/core/lkvc_datapath.sv
// entry tags, recency ranks, occupancy and value store
module lkvc_datapath
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic               req_type_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               cfg_valid_i,
  input  logic [CAP_W-1:0]   cfg_wdata_i,
  output logic               found_o,
  output logic [VALUE_W-1:0] read_value_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [OCC_W-1:0] OCC_ONE = OCC_W'(1);
  localparam logic [CMP_W-1:0] CMP_ONE = CMP_W'(1);
  localparam logic [CMP_W-1:0] ENT_C   = CMP_W'(ENTRIES);

  // request registers
  logic               is_put_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] val_q;

  // entry state
  logic [KEY_W-1:0]   tag_q  [ENTRIES];
  logic [IDX_W-1:0]   rank_q [ENTRIES];
  logic [IDX_W-1:0]   rank_d [ENTRIES];
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [CAP_W-1:0]   cap_q;

  // lookup result
  logic               hit_q;
  logic [IDX_W-1:0]   hit_idx_q;

  logic [ENTRIES-1:0] match;
  logic               match_any;
  logic [IDX_W-1:0]   match_idx;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   hit_rank;
  logic [OCC_W-1:0]   occ_m1;
  logic [CMP_W-1:0]   cap_ext, cap_eff;
  logic [VALUE_W-1:0] ram_rdata;

  // parallel key compare, lowest matching slot wins
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid_q[i] && (tag_q[i] == key_q);
      if (match[i]) begin
        match_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    match_any = |match;
  end

  // capacity: zero acts as one, saturate at entry count
  always_comb begin
    cap_ext = CMP_W'(cap_q);
    if (cap_ext == '0) begin
      cap_eff = CMP_ONE;
    end else if (cap_ext > ENT_C) begin
      cap_eff = ENT_C;
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign occ_m1   = occ_q - OCC_ONE;
  assign hit_rank = rank_q[hit_idx_q];

  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (cmd_i.access) begin
      // move hit entry to the front
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && (IDX_W'(i) != hit_idx_q) && (rank_q[i] < hit_rank)) begin
          rank_d[i] = rank_q[i] + IDX_W'(1);
        end
      end
      rank_d[hit_idx_q] = '0;
    end else if (cmd_i.evict) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && (rank_q[i] == occ_m1[IDX_W-1:0])) begin
          valid_d[i] = 1'b0;
          rank_d[i]  = '0;
        end
      end
      occ_d = occ_m1;
    end else if (cmd_i.insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i]) begin
          rank_d[i] = rank_q[i] + IDX_W'(1);
        end
      end
      valid_d[free_idx] = 1'b1;
      rank_d[free_idx]  = '0;
      occ_d             = occ_q + OCC_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      occ_q     <= '0;
      cap_q     <= CAP_RESET;
      hit_q     <= 1'b0;
      hit_idx_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
      if (cfg_valid_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.lookup) begin
        hit_q     <= match_any;
        hit_idx_q <= match_idx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      is_put_q <= (req_type_i == REQ_PUT);
      key_q    <= key_i;
      val_q    <= value_i;
    end
    if (cmd_i.insert) begin
      tag_q[free_idx] <= key_q;
    end
  end

  lkvc_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    ((cmd_i.access && is_put_q) || cmd_i.insert),
    .waddr_i (cmd_i.insert ? free_idx : hit_idx_q),
    .wdata_i (val_q),
    .re_i    (cmd_i.access && !is_put_q),
    .raddr_i (hit_idx_q),
    .rdata_o (ram_rdata)
  );

  assign status_o.hit    = hit_q;
  assign status_o.is_put = is_put_q;
  assign status_o.full   = (CMP_W'(occ_q) >= cap_eff);

  assign found_o      = hit_q;
  assign read_value_o = (hit_q && !is_put_q) ? ram_rdata : '0;

endmodule

### rtl/core/lru_key_value_cache.sv
// top level of the fully associative lru key/value cache
//
// one request at a time: a transaction is taken when start is high and busy is
// low, and its result appears on found_o / read_value_o for exactly one cycle
// with done_o high; the receiver cannot stall, so it must sample on that cycle.
// a get, a put to a held key and a get miss step from the accepting edge
// through compare, act and result; a put of a new key steps through compare,
// act, the evict loop and result: the controller drops one least recent entry
// per cycle while occupancy is at or above capacity, then does the insert in
// the evict state before moving on to the result. busy falls right
// after the result cycle, so the next transaction can start on the following
// edge. capacity (reset 8, zero acts as 1, saturates at ENTRIES) is written
// through the cfg channel, which is always ready; write it only while idle.
// lowering it evicts nothing until the next put of a new key. values live in
// a ram with a registered read port; keys sit in flops for the parallel compare.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request transaction
  input  logic               start,
  output logic               busy,
  input  logic               req_type_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [VALUE_W-1:0] value_i,
  // result transaction, one cycle, no back-pressure
  output logic               done_o,
  output logic               found_o,
  output logic [VALUE_W-1:0] read_value_o,
  // capacity write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CAP_W-1:0]   cfg_wdata_i
);

  cmd_t    cmd;
  status_t status;

  // capacity register can be written any cycle
  assign cfg_ready_o = 1'b1;

  // sequencer: idle, compare, act, evict loop, result
  lkvc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  // tags, ranks, occupancy, capacity and value ram
  lkvc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_wdata_i  (cfg_wdata_i),
    .found_o      (found_o),
    .read_value_o (read_value_o)
  );

endmodule

### rtl/core/lkvc_checker.sv
// port level checks for the lru key/value cache, bound to the top level
module lkvc_checker
  import lkvc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_i,
  input logic               done_i,
  input logic               found_i,
  input logic [VALUE_W-1:0] read_value_i
);

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i) |=> busy_i)
    else $error("accepted transaction did not raise busy");

  // a result only shows up while a transaction is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> busy_i)
    else $error("result strobe while idle");

  // one result per transaction, held for one cycle only
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !done_i)
    else $error("result strobe longer than one cycle");

  // busy ends only right after a result
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_i) |-> $past(done_i))
    else $error("busy dropped without a result");

  // a miss never returns data
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && !found_i) |-> (read_value_i == '0))
    else $error("nonzero read value on a miss");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start),
  .busy_i       (busy),
  .done_i       (done_o),
  .found_i      (found_o),
  .read_value_i (read_value_o)
);

### tb/lru_key_value_cache_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the lru key/value cache with a shadow cache predictor
module lru_key_value_cache_test;
  import lkvc_pkg::*;

  localparam int unsigned SLOTS       = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;

  // one pending operation: a cache request or a capacity write
  typedef struct {
    bit                 is_cfg;
    logic               req_type;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [CAP_W-1:0]   cap;
  } cache_op_t;

  typedef struct {
    logic               found;
    logic [VALUE_W-1:0] read_value;
  } lookup_result_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               start        = 1'b0;
  logic               busy;
  logic               req_type_i   = REQ_GET;
  logic [KEY_W-1:0]   key_i        = '0;
  logic [VALUE_W-1:0] value_i      = '0;
  logic               done_o;
  logic               found_o;
  logic [VALUE_W-1:0] read_value_o;
  logic               cfg_valid_i  = 1'b0;
  logic               cfg_ready_o;
  logic [CAP_W-1:0]   cfg_wdata_i  = '0;

  lru_key_value_cache #(
    .ENTRIES(SLOTS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .found_o     (found_o),
    .read_value_o(read_value_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cache_op_t      op_queue[$];
  lookup_result_t expected_results[$];
  bit             failed = 1'b0;
  int unsigned    cycle_count = 0;

  // shadow copy of the cache contents and the capacity register
  logic [KEY_W-1:0]   shadow_keys  [SLOTS];
  logic [VALUE_W-1:0] shadow_values[SLOTS];
  bit                 shadow_valid [SLOTS];
  logic [2:0]         shadow_rank  [SLOTS];
  logic [CAP_W-1:0]   shadow_cap = CAP_RESET;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      shadow_keys[i]   = '0;
      shadow_values[i] = '0;
      shadow_valid[i]  = 1'b0;
      shadow_rank[i]   = '0;
    end
  end

  function automatic int find_slot(input logic [KEY_W-1:0] key);
    for (int i = 0; i < SLOTS; i++)
      if (shadow_valid[i] && shadow_keys[i] == key) return i;
    return -1;
  endfunction

  function automatic int unsigned held_count();
    int unsigned n;
    n = 0;
    for (int i = 0; i < SLOTS; i++)
      if (shadow_valid[i]) n++;
    return n;
  endfunction

  // make slot s the most recent; entries that were more recent age by one
  function automatic void promote(input int s);
    logic [2:0] r;
    r = shadow_rank[s];
    for (int i = 0; i < SLOTS; i++)
      if (shadow_valid[i] && i != s && shadow_rank[i] < r) shadow_rank[i]++;
    shadow_rank[s] = '0;
  endfunction

  // work out the result of one accepted request and update the shadow cache
  task automatic predict_request(input cache_op_t op);
    lookup_result_t res;
    int             hit;
    int unsigned    cap;
    int unsigned    n;
    hit = find_slot(op.key);
    res.found = (hit >= 0);
    res.read_value = '0;
    if (op.req_type == REQ_GET) begin
      if (hit >= 0) begin
        res.read_value = shadow_values[hit];
        promote(hit);
      end
    end else if (hit >= 0) begin
      shadow_values[hit] = op.value;
      promote(hit);
    end else begin
      // zero acts as one, anything above the slot count saturates
      if (shadow_cap == 0) cap = 1;
      else if (shadow_cap > SLOTS) cap = SLOTS;
      else cap = shadow_cap;
      // drop least recent entries until there is room under the capacity
      while (held_count() >= cap) begin
        n = held_count();
        for (int i = 0; i < SLOTS; i++) begin
          if (shadow_valid[i] && shadow_rank[i] == n - 1) begin
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = '0;
            break;
          end
        end
      end
      // new key goes into the lowest free slot as most recent
      for (int i = 0; i < SLOTS; i++) begin
        if (!shadow_valid[i]) begin
          for (int j = 0; j < SLOTS; j++)
            if (shadow_valid[j]) shadow_rank[j]++;
          shadow_valid[i]  = 1'b1;
          shadow_keys[i]   = op.key;
          shadow_values[i] = op.value;
          shadow_rank[i]   = '0;
          break;
        end
      end
    end
    expected_results.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: pulls from op_queue, holds start until the transaction is
  // taken, and only writes capacity once the cache has gone idle
  // ---------------------------------------------------------------------------
  cache_op_t   cur_op;
  int unsigned idle_left = 0;
  bit          in_burst  = 1'b0;
  bit          req_taken;
  bit          cap_taken;
  bit          line_free;
  bit          raise_req;
  bit          raise_cfg;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start       <= 1'b0;
      req_type_i  <= REQ_GET;
      key_i       <= '0;
      value_i     <= '0;
      cfg_valid_i <= 1'b0;
      cfg_wdata_i <= '0;
    end else begin
      req_taken = start && !busy;
      cap_taken = cfg_valid_i && cfg_ready_o;
      if (req_taken) predict_request(cur_op);
      if (cap_taken) shadow_cap = cur_op.cap;

      // keep offering whatever has not been taken yet
      raise_req = start && !req_taken;
      raise_cfg = cfg_valid_i && !cap_taken;
      line_free = !raise_req && !raise_cfg;

      if (line_free && op_queue.size() != 0) begin
        if (idle_left != 0) begin
          idle_left--;
        end else if (!op_queue[0].is_cfg) begin
          cur_op    = op_queue.pop_front();
          raise_req = 1'b1;
          // switch now and then between gap-free bursts and random gaps
          if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
          idle_left = in_burst ? 0 : $urandom_range(0, 15);
        end else if (expected_results.size() == 0 && !busy && !req_taken) begin
          // capacity changes only with nothing in flight
          cur_op    = op_queue.pop_front();
          raise_cfg = 1'b1;
        end
      end

      start       <= raise_req;
      cfg_valid_i <= raise_cfg;
      if (raise_req && !start) begin
        req_type_i <= cur_op.req_type;
        key_i      <= cur_op.key;
        value_i    <= cur_op.value;
      end else if (raise_req && req_taken) begin
        req_type_i <= cur_op.req_type;
        key_i      <= cur_op.key;
        value_i    <= cur_op.value;
      end
      if (raise_cfg && !cfg_valid_i) cfg_wdata_i <= cur_op.cap;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: every done strobe is matched against the oldest prediction
  // ---------------------------------------------------------------------------
  lookup_result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing pending, actual found %0b read_value %h",
                 $time, found_o, read_value_o);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (found_o !== want.found) begin
          $display("%0t: found mismatch, expected %0b, actual %0b",
                   $time, want.found, found_o);
          failed = 1'b1;
        end
        if (read_value_o !== want.read_value) begin
          $display("%0t: read_value mismatch, expected %h, actual %h",
                   $time, want.read_value, read_value_o);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[lru_key_value_cache] ERROR");
      $finish;
    end
  end

  task automatic add_req(input logic kind, input logic [KEY_W-1:0] key,
                         input logic [VALUE_W-1:0] value);
    cache_op_t op;
    op.is_cfg   = 1'b0;
    op.req_type = kind;
    op.key      = key;
    op.value    = value;
    op.cap      = '0;
    op_queue.push_back(op);
  endtask

  task automatic add_cfg(input logic [CAP_W-1:0] cap);
    cache_op_t op;
    op.is_cfg   = 1'b1;
    op.req_type = REQ_GET;
    op.key      = '0;
    op.value    = '0;
    op.cap      = cap;
    op_queue.push_back(op);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] key_pool[12];
  logic [KEY_W-1:0] base_key;
  logic [KEY_W-1:0] pick_key;
  logic [CAP_W-1:0] pick_cap;
  int unsigned      pool_size;

  initial begin
    // directed: empty miss, both key extremes, update, eviction at full
    add_req(REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    add_req(REQ_PUT, 32'h0000_0000, 32'h0000_0000);
    add_req(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    add_req(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    add_req(REQ_PUT, 32'h0000_0000, 32'h1234_5678);
    add_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    for (int k = 1; k <= 6; k++) add_req(REQ_PUT, k, 32'hA5A5_0000 + k);
    // cache now full; this one pushes out the least recent entry
    add_req(REQ_PUT, 32'h0000_0007, 32'h5A5A_5A5A);
    add_req(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    // capacity zero acts as one; lowering evicts nothing until a new key
    add_cfg(4'd0);
    add_req(REQ_GET, 32'h0000_0003, 32'h0000_0000);
    add_req(REQ_PUT, 32'h0000_0002, 32'hDEAD_BEEF);
    add_req(REQ_PUT, 32'h8000_0000, 32'hCAFE_F00D);
    add_req(REQ_GET, 32'h0000_0003, 32'h0000_0000);
    add_req(REQ_GET, 32'h8000_0000, 32'h0000_0000);
    // capacity above the slot count saturates
    add_cfg(4'd15);
    for (int k = 0; k < 9; k++) add_req(REQ_PUT, 32'h0100_0000 << (k % 8), $urandom);
    add_req(REQ_GET, 32'h8000_0000, 32'h0000_0000);

    // random phases: small key pools so hits, updates and evictions all occur
    for (int p = 0; p < 13; p++) begin
      case ($urandom_range(0, 9))
        0:       pick_cap = 4'd0;
        1:       pick_cap = CAP_W'($urandom_range(9, 15));
        2:       pick_cap = 4'd8;
        3:       pick_cap = 4'd1;
        default: pick_cap = CAP_W'($urandom_range(1, 8));
      endcase
      add_cfg(pick_cap);
      pool_size = $urandom_range(2, 12);
      base_key  = $urandom;
      for (int k = 0; k < pool_size; k++) begin
        case ($urandom_range(0, 7))
          0:       key_pool[k] = 32'h0000_0000;
          1:       key_pool[k] = 32'hFFFF_FFFF;
          2, 3:    key_pool[k] = base_key ^ (32'h1 << $urandom_range(0, 31));
          default: key_pool[k] = $urandom;
        endcase
      end
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 15) == 0) pick_key = $urandom;
        else pick_key = key_pool[$urandom_range(0, pool_size - 1)];
        add_req($urandom_range(0, 1) ? REQ_PUT : REQ_GET, pick_key, $urandom);
      end
    end
    add_cfg(CAP_RESET);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every operation to be taken and every result to arrive
    @(posedge clk_i);
    while (op_queue.size() != 0 || start || cfg_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (!failed && expected_results.size() == 0) begin
      $display("[lru_key_value_cache] OK");
    end else begin
      $display("[lru_key_value_cache] ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_ram.sv
rtl/core/lkvc_ctrl.sv
rtl/core/lkvc_datapath.sv
rtl/core/lru_key_value_cache.sv
rtl/core/lkvc_checker.sv
tb/lru_key_value_cache_test.sv
